[src/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

	// Field widths of one request and one result
	localparam int CMD_W      = 3;
	localparam int VAL_W      = 32;
	localparam int STAT_W     = 2;
	localparam int COUNT_W    = 7;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 48;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

endpackage

`default_nettype wire

[src/circular_deque_top.sv]
`default_nettype none

// Double-ended queue of DEPTH signed 32-bit words held in a single-port-read,
// single-port-write synchronous memory used as a ring. Each request pushes at
// the front or rear, pops from either end, or lists the contents front to rear.
// A push result goes straight to the output register; a pop result passes the
// memory read register, then the output register. A list of N elements gives
// one result per cycle unless the output stalls, paced by the one memory read
// port. Requests are taken one at a time: the next request is accepted once
// every result of the current one has reached the output register and that
// register is empty or being read in the same cycle, so a stalled master side
// also stalls the slave side. Errors (push on full, pop or list on empty) give
// one result with status full or empty and leave the state as it was.
// Undefined command codes are dropped without a result.
module circular_deque_top #(
	parameter int DEPTH = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// [2:0] command, [34:3] push_value, [39:35] zero
	input  wire  [cdq_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// [1:0] status, [33:2] data_value, [40:34] element_count, [47:41] zero
	output logic [cdq_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	import cdq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	// Ring storage and its registered read data
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [IDX_W-1:0] slot_q, slot_d;

	logic              m_tvalid_q;
	logic [STAT_W-1:0] out_status_q, out_status_d;
	logic [VAL_W-1:0]  out_data_q, out_data_d;
	logic [COUNT_W-1:0] out_count_q;
	logic              out_last_q, out_last_d;
	logic              out_load;
	logic              out_free;

	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  wr_addr, rd_addr;

	logic [CMD_W-1:0]  cmd;
	logic [VAL_W-1:0]  push_value;
	logic              accept;
	logic              full, empty;

	logic [IDX_W-1:0]  front_inc, front_dec, slot_inc;
	logic [SUM_W-1:0]  tail_sum, rear_sum;
	logic [IDX_W-1:0]  tail_slot, rear_slot;

	// Unpack request
	assign cmd        = s_tdata[CMD_W-1:0];
	assign push_value = s_tdata[CMD_W+VAL_W-1:CMD_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign full  = (occ_q == CNT_W'(DEPTH));
	assign empty = (occ_q == '0);

	// Ring index arithmetic, each wrap done with a compare and an add or subtract
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign slot_inc  = (slot_q == IDX_W'(DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);

	assign tail_sum  = SUM_W'(front_q) + SUM_W'(occ_q);
	assign rear_sum  = tail_sum - SUM_W'(1);
	assign tail_slot = IDX_W'((tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum);
	assign rear_slot = IDX_W'((rear_sum >= SUM_W'(DEPTH)) ? rear_sum - SUM_W'(DEPTH) : rear_sum);

	// Decode request and step through reads
	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		occ_d        = occ_q;
		left_d       = left_q;
		slot_d       = slot_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		wr_addr      = tail_slot;
		rd_addr      = front_q;
		out_load     = 1'b0;
		out_status_d = STAT_OK;
		out_data_d   = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
							out_load = 1'b1;
							if (full) begin
								out_status_d = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								occ_d  = occ_q + CNT_W'(1);
								if (empty) begin
									front_d = '0;
									wr_addr = '0;
								end else if (cmd == CMD_PUSH_FRONT) begin
									front_d = front_dec;
									wr_addr = front_dec;
								end
							end
						end
						CMD_POP_FRONT, CMD_POP_REAR: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								mem_re  = 1'b1;
								left_d  = CNT_W'(1);
								state_d = ST_READ;
								occ_d   = occ_q - CNT_W'(1);
								if (cmd == CMD_POP_REAR) begin
									rd_addr = rear_slot;
								end
								if (occ_q == CNT_W'(1)) begin
									front_d = '0;
								end else if (cmd == CMD_POP_FRONT) begin
									front_d = front_inc;
								end
							end
						end
						CMD_LIST: begin
							if (empty) begin
								out_load     = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								mem_re  = 1'b1;
								slot_d  = front_inc;
								left_d  = occ_q;
								state_d = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_data_d = rd_data_q;
					out_last_d = (left_q == CNT_W'(1));
					if (left_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end else begin
						mem_re  = 1'b1;
						rd_addr = slot_q;
						slot_d  = slot_inc;
						left_d  = left_q - CNT_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= push_value;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			occ_q      <= '0;
			left_q     <= '0;
			slot_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			left_q  <= left_d;
			slot_q  <= slot_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold result payload until taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_count_q  <= COUNT_W'(occ_d);
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(M_TDATA_W - STAT_W - VAL_W - COUNT_W)'(0),
		out_count_q, out_data_q, out_status_q};

endmodule

`default_nettype wire
